[design/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the mask key enumerator checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define MKE_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("mask key enumerator check failed");

// Checked on every rising clock edge, reset included.
`define MKE_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("mask key enumerator check failed");

`endif

[design/mke_pkg.sv]
// ---------------------------------------------------------------------------
// Mask key enumerator package
// Sizes, request codes and controller/datapath interface types.
// ---------------------------------------------------------------------------
`default_nettype none

package mke_pkg;

   localparam int MAX_POSITIONS = 16;
   localparam int POS_W         = $clog2(MAX_POSITIONS);
   localparam int CHARSET_DEPTH = 256;
   localparam int CHAR_W        = 8;
   localparam int INDEX_W       = $clog2(CHARSET_DEPTH);
   localparam int ADDR_W        = POS_W + INDEX_W;
   localparam int SEQ_W         = 64;
   localparam int DIV_BITS      = 4;
   localparam int DIV_CYCLES    = SEQ_W / DIV_BITS;
   localparam int DIV_CNT_W     = $clog2(DIV_CYCLES);
   localparam int KEY_LEN_W     = 5;
   localparam int KEY_LIMIT     = (MAX_POSITIONS < 16) ? MAX_POSITIONS : 16;
   localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = KEY_LEN_W'(8);

   localparam int OP_W       = 2;
   localparam int REQ_DATA_W = 88;
   localparam int RSP_DATA_W = 24;

   typedef enum logic [OP_W-1:0] {
      OP_WRITE_CHAR = 2'd0,
      OP_WRITE_LEN  = 2'd1,
      OP_SEEK       = 2'd2,
      OP_STEP       = 2'd3
   } opcode_type;

   typedef struct packed {
      logic accept;
      logic seek_run;
      logic step_run;
      logic advance;
   } cmd_type;

   typedef struct packed {
      logic div_last;
      logic pos_zero;
      logic pos_last;
      logic step_stop;
   } status_type;

endpackage

`default_nettype wire

[design/mke_ctrl.sv]
// ---------------------------------------------------------------------------
// Mask key enumerator controller
// Sequences request intake, the seek divider, the odometer step and the
// character-by-character emission of the key.
// ---------------------------------------------------------------------------
`default_nettype none

module mke_ctrl
   import mke_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire opcode_type opcode,
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output cmd_type         cmd,
   input  wire status_type status
);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_SEEK  = 5'b00010,
      ST_STEP  = 5'b00100,
      ST_FETCH = 5'b01000,
      ST_SHOW  = 5'b10000
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_SHOW);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               unique case (opcode) inside
                  OP_SEEK:                     state_in = ST_SEEK;
                  OP_STEP:                     state_in = ST_STEP;
                  OP_WRITE_CHAR, OP_WRITE_LEN: state_in = ST_IDLE;
                  default:                     state_in = ST_IDLE;
               endcase
            end
         end
         ST_SEEK: begin
            cmd.seek_run = 1'b1;
            if (status.div_last && status.pos_zero) begin
               state_in = ST_FETCH;
            end
         end
         ST_STEP: begin
            cmd.step_run = 1'b1;
            if (status.step_stop || status.pos_zero) begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            state_in = ST_SHOW;
         end
         ST_SHOW: begin
            if (rsp_tready) begin
               cmd.advance = 1'b1;
               state_in    = status.pos_last ? ST_IDLE : ST_FETCH;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

[design/mke_datapath.sv]
// ---------------------------------------------------------------------------
// Mask key enumerator datapath
// Charset memory, length table, digit counters, a radix-16 restoring divider
// for seek and the result fields.
// ---------------------------------------------------------------------------
`default_nettype none

module mke_datapath
   import mke_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   input  wire opcode_type            opcode,
   input  wire logic                  csr_wr_en,
   input  wire logic [KEY_LEN_W-1:0]  csr_wr_data,
   input  wire cmd_type               cmd,
   output status_type                 status,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   output logic                       rsp_tlast,
   output logic                       rsp_tuser
);

   logic [POS_W-1:0]   req_position;
   logic [INDEX_W-1:0] req_char_index;
   logic [CHAR_W-1:0]  req_value;
   logic [SEQ_W-1:0]   req_sequence;

   assign req_position   = req_tdata[POS_W-1:0];
   assign req_char_index = req_tdata[POS_W +: INDEX_W];
   assign req_value      = req_tdata[POS_W+INDEX_W +: CHAR_W];
   assign req_sequence   = req_tdata[POS_W+INDEX_W+CHAR_W +: SEQ_W];

   logic [KEY_LEN_W-1:0] key_len_ff;
   logic [POS_W-1:0]     last_pos;
   logic [POS_W-1:0]     pos_ff;
   logic [CHAR_W-1:0]    len_ff [MAX_POSITIONS];
   logic [CHAR_W-1:0]    ctr_ff [MAX_POSITIONS];
   logic [SEQ_W-1:0]     seq_ff;
   logic [CHAR_W-1:0]    rem_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic                 wrapped_ff;
   logic [CHAR_W-1:0]    rd_ff;
   logic [CHAR_W-1:0]    charset_mem [CHARSET_DEPTH*MAX_POSITIONS];

   logic [CHAR_W-1:0] base;
   logic [CHAR_W-1:0] cur_digit;
   logic [CHAR_W:0]   next_digit;
   logic [CHAR_W:0]   trial;
   logic [CHAR_W-1:0] rem_in;
   logic [SEQ_W-1:0]  seq_in;
   logic              mem_we;

   always_comb begin
      if (key_len_ff == '0) begin
         last_pos = '0;
      end else if (int'(key_len_ff) > KEY_LIMIT) begin
         last_pos = POS_W'(KEY_LIMIT - 1);
      end else begin
         last_pos = POS_W'(key_len_ff - 1'b1);
      end
   end

   assign base       = len_ff[pos_ff];
   assign cur_digit  = ctr_ff[pos_ff];
   assign next_digit = {1'b0, cur_digit} + 1'b1;

   assign status.div_last  = (cnt_ff == DIV_CNT_W'(DIV_CYCLES - 1));
   assign status.pos_zero  = (pos_ff == '0);
   assign status.pos_last  = (pos_ff == last_pos);
   assign status.step_stop = (next_digit < {1'b0, base});

   // Four restoring division steps per cycle; the quotient replaces the
   // dividend bit by bit as it is shifted out.
   always_comb begin
      rem_in = rem_ff;
      seq_in = seq_ff;
      trial  = '0;
      for (int b = 0; b < DIV_BITS; b++) begin
         trial  = {rem_in, seq_in[SEQ_W-1]};
         seq_in = {seq_in[SEQ_W-2:0], 1'b0};
         if (trial >= {1'b0, base}) begin
            trial     = trial - {1'b0, base};
            seq_in[0] = 1'b1;
         end
         rem_in = trial[CHAR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_len_ff <= KEY_LEN_RESET;
         pos_ff     <= '0;
         cnt_ff     <= '0;
         wrapped_ff <= 1'b0;
         for (int i = 0; i < MAX_POSITIONS; i++) begin
            len_ff[i] <= '1;
            ctr_ff[i] <= '0;
         end
      end else begin
         if (csr_wr_en) begin
            key_len_ff <= csr_wr_data;
         end
         if (cmd.accept) begin
            pos_ff     <= last_pos;
            cnt_ff     <= '0;
            wrapped_ff <= 1'b0;
            if (opcode == OP_WRITE_LEN) begin
               len_ff[req_position] <= (req_value == '0) ? CHAR_W'(1) : req_value;
            end
         end
         if (cmd.seek_run) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (status.div_last) begin
               ctr_ff[pos_ff] <= rem_in;
               if (!status.pos_zero) begin
                  pos_ff <= pos_ff - 1'b1;
               end
            end
         end
         if (cmd.step_run) begin
            if (status.step_stop) begin
               ctr_ff[pos_ff] <= next_digit[CHAR_W-1:0];
               pos_ff         <= '0;
            end else begin
               ctr_ff[pos_ff] <= '0;
               if (status.pos_zero) begin
                  wrapped_ff <= 1'b1;
               end else begin
                  pos_ff <= pos_ff - 1'b1;
               end
            end
         end
         if (cmd.advance) begin
            pos_ff <= pos_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         seq_ff <= req_sequence;
         rem_ff <= '0;
      end else if (cmd.seek_run) begin
         seq_ff <= seq_in;
         rem_ff <= status.div_last ? '0 : rem_in;
      end
   end

   assign mem_we = cmd.accept && (opcode == OP_WRITE_CHAR);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         charset_mem[{req_position, req_char_index}] <= req_value;
      end
      rd_ff <= charset_mem[{pos_ff, cur_digit}];
   end

   assign rsp_tdata = {{(RSP_DATA_W - POS_W - 2*CHAR_W){1'b0}}, cur_digit, rd_ff, pos_ff};
   assign rsp_tlast = status.pos_last;
   assign rsp_tuser = wrapped_ff;

endmodule

`default_nettype wire

[design/mask_key_enumerator.sv]
// ---------------------------------------------------------------------------
// Mask key enumerator
// Generates candidate keys from a per-position character mask.
// ---------------------------------------------------------------------------
// Requests arrive on the req_ stream; tuser carries the opcode. Charset
// character and length writes produce no result. A seek or a step
// produces one result per key position on the rsp_ stream, position 0
// first, with tlast on the final character and tuser set on every
// character of a step that wrapped back to the first key.
// A seek runs the 64-bit sequence number through a divider that retires
// four quotient bits per cycle, dividing once for each key position.
// A step walks the counters from the last position, one position per cycle,
// until the carry stops. Each character is then read from the charset memory
// and offered on the result stream until it is taken. A new request is taken
// only once the whole key has been delivered; a stalled receiver simply
// holds the current character.
// Reset sets every charset length to 255, every counter to zero and the key
// length to 8; the charset memory itself is not cleared and must be written
// before it is used. csr_wr_en writes the key length at any idle time.
// ---------------------------------------------------------------------------
`default_nettype none

module mask_key_enumerator
   import mke_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // position[3:0], char_index[11:4], value[19:12], sequence_req[83:20], zero
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // opcode[1:0]
   input  wire logic [OP_W-1:0]       req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // position_res[3:0], character[11:4], digit[19:12], zero
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   output logic                       rsp_tlast,
   // wrapped[0]
   output logic                       rsp_tuser,
   input  wire logic                  csr_wr_en,
   input  wire logic [KEY_LEN_W-1:0]  csr_wr_data
);

   cmd_type    cmd;
   status_type status;
   opcode_type opcode;

   assign opcode = opcode_type'(req_tuser);

   mke_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .opcode     (opcode),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   mke_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .opcode      (opcode),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .status      (status),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser)
   );

endmodule

`default_nettype wire

[design/mke_checker.sv]
// ---------------------------------------------------------------------------
// Mask key enumerator checker
// Port-level assertions, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module mke_checker
   import mke_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_tvalid,
   input wire logic                  req_tready,
   input wire logic [OP_W-1:0]       req_tuser,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata
);

   `MKE_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid)
   `MKE_ASSERT(a_rsp_stable, clock, reset, rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
   `MKE_ASSERT_ALWAYS(a_reset_quiet, clock, reset |=> !rsp_tvalid)
   `MKE_ASSERT(a_no_overlap, clock, reset, rsp_tvalid |-> !req_tready)
   `MKE_ASSERT(a_seek_latency, clock, reset, req_tvalid && req_tready && (req_tuser == OP_SEEK) |=> !rsp_tvalid)

endmodule

bind mask_key_enumerator mke_checker u_mke_checker (.*);

`default_nettype wire

[dv/tb_mask_key_enumerator.sv]
// ---------------------------------------------------------------------------
// Mask key enumerator testbench
// Sends charset loads, seeks and steps as requests and checks every emitted
// key character against a local prediction of the charset memory, the
// charset lengths and the digit counters, under random stalls on both sides.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_mask_key_enumerator;
   import mke_pkg::*;

   localparam int LIMIT = 2000000;

   typedef struct packed {
      logic [POS_W-1:0]   position;
      logic [CHAR_W-1:0]  symbol;
      logic [INDEX_W-1:0] digit;
      logic               last;
      logic               wrapped;
   } key_char_type;

   class key_checker;
      logic [CHAR_W-1:0]    charset [MAX_POSITIONS][CHARSET_DEPTH];
      bit                   written [MAX_POSITIONS][CHARSET_DEPTH];
      int unsigned          lengths [MAX_POSITIONS];
      logic [INDEX_W-1:0]   counters [MAX_POSITIONS];
      logic [KEY_LEN_W-1:0] key_len;
      key_char_type         pending [$];
      int                   mismatches;

      function new();
         for (int p = 0; p < MAX_POSITIONS; p++) begin
            lengths[p] = 255;
            counters[p] = '0;
            for (int i = 0; i < CHARSET_DEPTH; i++) written[p][i] = 1'b0;
         end
         key_len = KEY_LEN_RESET;
         mismatches = 0;
      endfunction

      function int key_positions();
         if (key_len < 1) return 1;
         if (key_len > KEY_LIMIT) return KEY_LIMIT;
         return int'(key_len);
      endfunction

      // The last position is the least significant digit for both a seek and a step.
      function void advance_counters(input opcode_type op, input logic [SEQ_W-1:0] seq,
                                     output logic [INDEX_W-1:0] digits [MAX_POSITIONS],
                                     output bit wrapped);
         int               n;
         logic [SEQ_W-1:0] rest;
         int unsigned      bump;
         bit               carry;
         n = key_positions();
         digits = counters;
         rest = seq;
         carry = 1'b1;
         for (int i = n - 1; i >= 0; i--) begin
            if (op == OP_SEEK) begin
               digits[i] = INDEX_W'(rest % lengths[i]);
               rest = rest / lengths[i];
            end else if (carry) begin
               bump = digits[i] + 1;
               if (bump < lengths[i]) begin
                  digits[i] = INDEX_W'(bump);
                  carry = 1'b0;
               end else begin
                  digits[i] = '0;
               end
            end
         end
         wrapped = (op == OP_STEP) && carry;
      endfunction

      function bit find_unwritten(input opcode_type op, input logic [SEQ_W-1:0] seq,
                                  output int unsigned pos, output int unsigned idx);
         logic [INDEX_W-1:0] digits [MAX_POSITIONS];
         bit                 wrapped;
         advance_counters(op, seq, digits, wrapped);
         for (int p = 0; p < key_positions(); p++) begin
            if (!written[p][digits[p]]) begin
               pos = p;
               idx = digits[p];
               return 1'b1;
            end
         end
         return 1'b0;
      endfunction

      function void note_request(input opcode_type op, input logic [REQ_DATA_W-1:0] data);
         logic [POS_W-1:0]   pos;
         logic [INDEX_W-1:0] idx;
         logic [CHAR_W-1:0]  value;
         logic [SEQ_W-1:0]   seq;
         bit                 wrapped;
         int                 n;
         pos = data[3:0];
         idx = data[11:4];
         value = data[19:12];
         seq = data[83:20];
         case (op)
            OP_WRITE_CHAR: begin
               charset[pos][idx] = value;
               written[pos][idx] = 1'b1;
            end
            OP_WRITE_LEN: begin
               lengths[pos] = (value == 0) ? 1 : value;
            end
            default: begin
               advance_counters(op, seq, counters, wrapped);
               n = key_positions();
               for (int p = 0; p < n; p++)
                  pending.push_back('{position: POS_W'(p), symbol: charset[p][counters[p]],
                                      digit: counters[p], last: (p == n - 1),
                                      wrapped: wrapped});
            end
         endcase
      endfunction

      function void check_char(input key_char_type got);
         key_char_type want;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Unexpected key character at position %0d.", got.position);
            return;
         end
         want = pending.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
               $write("Key character mismatch: expected pos %0d char %h digit %0d last %b wrap %b, ",
                      want.position, want.symbol, want.digit, want.last, want.wrapped);
               $display("got pos %0d char %h digit %0d last %b wrap %b.",
                        got.position, got.symbol, got.digit, got.last, got.wrapped);
            end
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [OP_W-1:0]       req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  rsp_tuser;
   logic                  csr_wr_en = 1'b0;
   logic [KEY_LEN_W-1:0]  csr_wr_data = '0;

   bit          calm = 1'b0;
   int unsigned rsp_hold = 0;
   int unsigned cycle_count = 0;
   key_checker  chk = new();

   mask_key_enumerator u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   always @(negedge clock) begin
      if (rsp_hold != 0) begin
         rsp_tready <= 1'b0;
         rsp_hold <= rsp_hold - 1;
      end else begin
         rsp_tready <= 1'b1;
         if (!calm && $urandom_range(0, 7) == 0) rsp_hold <= $urandom_range(1, 14);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1)
         chk.check_char('{position: rsp_tdata[3:0], symbol: rsp_tdata[11:4],
                          digit: rsp_tdata[19:12], last: rsp_tlast, wrapped: rsp_tuser});
   end

   initial begin
      while (cycle_count < LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb_mask_key_enumerator: FAIL");
      $finish;
   end

   task automatic idle_sender(input int unsigned cycles);
      repeat (cycles) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
   endtask

   task automatic send_request(input opcode_type op, input logic [POS_W-1:0] pos,
                               input logic [INDEX_W-1:0] idx, input logic [CHAR_W-1:0] value,
                               input logic [SEQ_W-1:0] seq);
      logic [REQ_DATA_W-1:0] data;
      data = {4'b0, seq, value, idx, pos};
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata <= data;
      req_tuser <= op;
      @(posedge clock);
      while (req_tready !== 1'b1) @(posedge clock);
      chk.note_request(op, data);
      if (!calm && $urandom_range(0, 5) == 0) idle_sender($urandom_range(1, 14));
   endtask

   // Any charset entry that the key would read is written first.
   task automatic send_key_op(input opcode_type op, input logic [SEQ_W-1:0] seq);
      int unsigned pos;
      int unsigned idx;
      while (chk.find_unwritten(op, seq, pos, idx))
         send_request(OP_WRITE_CHAR, POS_W'(pos), INDEX_W'(idx), CHAR_W'($urandom),
                      {$urandom, $urandom});
      send_request(op, POS_W'($urandom), INDEX_W'($urandom), CHAR_W'($urandom), seq);
   endtask

   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (chk.pending.size() != 0) @(posedge clock);
   endtask

   task automatic set_key_length(input logic [KEY_LEN_W-1:0] value);
      drain();
      repeat (8) @(posedge clock);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      chk.key_len = value;
   endtask

   function automatic logic [SEQ_W-1:0] random_sequence();
      case ($urandom_range(0, 3))
         0: return SEQ_W'($urandom_range(0, 300));
         1: return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic logic [CHAR_W-1:0] random_length();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         2: return CHAR_W'($urandom);
         default: return CHAR_W'($urandom_range(1, 3));
      endcase
   endfunction

   task automatic run_random(input int count);
      int unsigned kind;
      for (int k = 0; k < count; k++) begin
         if (k == 10 || $urandom_range(0, 39) == 0) drain();
         kind = $urandom_range(0, 9);
         if (kind < 3)
            send_request(OP_WRITE_CHAR, POS_W'($urandom), INDEX_W'($urandom),
                         CHAR_W'($urandom), {$urandom, $urandom});
         else if (kind < 5)
            send_request(OP_WRITE_LEN, POS_W'($urandom), INDEX_W'($urandom),
                         random_length(), {$urandom, $urandom});
         else if (kind < 7)
            send_key_op(OP_SEEK, random_sequence());
         else
            send_key_op(OP_STEP, random_sequence());
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_request(OP_WRITE_LEN, 0, 0, 0, '0);
      send_request(OP_WRITE_LEN, 15, 255, 255, '1);
      send_request(OP_WRITE_CHAR, 15, 255, 8'hFF, '1);
      send_request(OP_WRITE_CHAR, 0, 0, 8'h00, '0);
      send_key_op(OP_SEEK, '0);
      send_key_op(OP_SEEK, '1);
      send_key_op(OP_STEP, '0);
      send_key_op(OP_SEEK, 254);
      // Shrinking the length below the current counter forces a carry on the next step.
      send_request(OP_WRITE_LEN, 7, 0, 3, '0);
      send_key_op(OP_STEP, '0);
      set_key_length(1);
      send_key_op(OP_STEP, '0);
      send_key_op(OP_STEP, '0);
      set_key_length(16);
      send_key_op(OP_SEEK, {$urandom, $urandom});
      send_key_op(OP_STEP, '0);

      run_random(60);
      set_key_length(0);
      run_random(50);
      set_key_length(31);
      run_random(50);
      set_key_length(2);
      run_random(50);
      set_key_length(KEY_LEN_W'($urandom_range(3, 15)));
      run_random(50);
      set_key_length(KEY_LEN_W'($urandom_range(1, 16)));
      calm = 1'b1;
      run_random(50);

      drain();
      repeat (40) @(posedge clock);
      if (chk.pending.size() != 0) begin
         $display("%0d key characters never arrived.", chk.pending.size());
         chk.mismatches++;
      end
      if (chk.mismatches == 0) $display("tb_mask_key_enumerator: PASS");
      else $display("tb_mask_key_enumerator: FAIL");
      $finish;
   end

endmodule

`default_nettype wire
